### rtl/core/e2il_pkg.sv
// shared types and constants of the ext2 inode locator
package e2il_pkg;

    localparam int MAX_GROUPS_DEFAULT = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_INODES     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INODES_PER_GROUP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INODE_BYTES      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE_LOG   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PARTITION_START  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUPS_IN_USE    = 3'd5;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RANGE    = 2'd1;
    localparam logic [1:0] STATUS_NO_GROUP = 2'd2;

    localparam logic [16:0] IPG_RESET         = 17'd1;
    localparam logic [12:0] INODE_BYTES_RESET = 13'd128;

    typedef struct packed {
        logic        mode;
        logic [2:0]  group_slot;
        logic [31:0] table_block;
        logic [31:0] inode_number;
    } in_t;

    typedef struct packed {
        logic [39:0] disk_sector;
        logic [8:0]  sector_offset;
        logic [1:0]  status;
    } out_t;

endpackage

### rtl/core/e2il_ram.sv
// generic single write port ram with registered read
module e2il_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ext2_inode_locator.sv
// ext2 inode locator: pipelined group split, table lookup and sector address
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------------
//  s_       | in        | s_valid / s_ready     | s_data   (mode, slot, block, inode)
//  m_       | out       | m_valid / m_ready     | m_data   (sector, offset, status)
//  cfg_     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle unless m_ready stalls; path: stage a, divider, stage r, output register
// GW = clog2(MAX_GROUPS); the restoring divider adds one stage per quotient bit
// synchronous active-low reset clears valid bits and sets config registers to defaults; table is unset
// stalls ripple back only through full stages; bubbles are squeezed out
module ext2_inode_locator #(
    parameter int MAX_GROUPS = e2il_pkg::MAX_GROUPS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  e2il_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output e2il_pkg::out_t                     m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [e2il_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [e2il_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int PW = 17 + GW;
    localparam int CW = (PW > 32) ? PW : 32;
    localparam int LW = (GW > 4) ? GW : 4;

    typedef struct packed {
        logic          load;
        logic [1:0]    status;
        logic [2:0]    slot;
        logic [31:0]   tb;
        logic [31:0]   rem;
        logic [GW-1:0] quo;
    } div_t;

    typedef struct packed {
        logic        load;
        logic [1:0]  status;
        logic [39:0] part;
        logic [8:0]  offset;
    } res_t;

    // configuration
    logic [31:0] total_inodes_reg;
    logic [16:0] ipg_reg;
    logic [12:0] inode_bytes_reg;
    logic [2:0]  bsl_reg;
    logic [31:0] part_start_reg;
    logic [3:0]  giu_reg;
    logic [PW-1:0] maxprod_reg;
    logic [PW-1:0] maxprod_next;
    logic [16:0] ipg_eff;

    assign cfg_ready = 1'b1;
    assign ipg_eff   = (ipg_reg == 17'd0) ? 17'd1 : ipg_reg;
    assign maxprod_next = PW'(ipg_eff) * PW'(MAX_GROUPS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_inodes_reg <= '0;
            ipg_reg          <= e2il_pkg::IPG_RESET;
            inode_bytes_reg  <= e2il_pkg::INODE_BYTES_RESET;
            bsl_reg          <= '0;
            part_start_reg   <= '0;
            giu_reg          <= '0;
            maxprod_reg      <= '0;
        end else begin
            maxprod_reg <= maxprod_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    e2il_pkg::CFG_TOTAL_INODES:     total_inodes_reg <= cfg_data;
                    e2il_pkg::CFG_INODES_PER_GROUP: ipg_reg          <= cfg_data[16:0];
                    e2il_pkg::CFG_INODE_BYTES:      inode_bytes_reg  <= cfg_data[12:0];
                    e2il_pkg::CFG_BLOCK_SIZE_LOG:   bsl_reg          <= cfg_data[2:0];
                    e2il_pkg::CFG_PARTITION_START:  part_start_reg   <= cfg_data;
                    e2il_pkg::CFG_GROUPS_IN_USE:    giu_reg          <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // stage enables, from the output back to the input
    logic          out_en;
    logic          r_en;
    logic [GW-1:0] d_en;
    logic          a_en;

    logic          a_valid_reg;
    e2il_pkg::in_t a_reg;
    div_t          a_out;
    logic [31:0]   a_nm1;
    logic          a_range_err;
    logic          a_over;

    logic [GW-1:0] d_valid_reg;
    div_t          d_reg  [GW];
    div_t          d_next [GW];

    logic          r_valid_reg;
    res_t          r_reg;
    res_t          r_next;

    logic           m_valid_reg;
    e2il_pkg::out_t m_data_reg;
    e2il_pkg::out_t m_data_next;

    logic [31:0]   ram_rdata;
    logic          ram_we;
    logic          ram_re;
    logic [GW-1:0] ram_waddr;

    assign out_en = !m_valid_reg || m_ready;
    assign r_en   = !r_valid_reg || out_en;
    assign a_en   = !a_valid_reg || d_en[0];
    assign s_ready = a_en;

    // stage a: range check and overflow of the group count
    assign a_nm1       = a_reg.inode_number - 32'd1;
    assign a_range_err = (a_reg.inode_number == 32'd0) ||
                         (a_reg.inode_number > total_inodes_reg);
    assign a_over      = CW'(a_nm1) >= CW'(maxprod_reg);

    always_comb begin
        a_out.load   = a_reg.mode;
        a_out.slot   = a_reg.group_slot;
        a_out.tb     = a_reg.table_block;
        a_out.rem    = a_nm1;
        a_out.quo    = '0;
        a_out.status = e2il_pkg::STATUS_OK;
        if (!a_reg.mode) begin
            priority if (a_range_err) begin
                a_out.status = e2il_pkg::STATUS_RANGE;
            end else if (a_over) begin
                a_out.status = e2il_pkg::STATUS_NO_GROUP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en && s_valid) begin
            a_reg <= s_data;
        end
    end

    // divider stages, one quotient bit each, most significant first
    for (genvar i = 0; i < GW; i++) begin : g_div
        div_t        src;
        logic        src_valid;
        logic [31:0] dsub;

        if (i == 0) begin : g_first
            assign src       = a_out;
            assign src_valid = a_valid_reg;
        end else begin : g_rest
            assign src       = d_reg[i-1];
            assign src_valid = d_valid_reg[i-1];
        end

        if (i == GW - 1) begin : g_last_en
            assign d_en[i] = !d_valid_reg[i] || r_en;
        end else begin : g_mid_en
            assign d_en[i] = !d_valid_reg[i] || d_en[i+1];
        end

        assign dsub = 32'(ipg_eff) << (GW - 1 - i);

        always_comb begin
            d_next[i] = src;
            if (src.rem >= dsub) begin
                d_next[i].rem            = src.rem - dsub;
                d_next[i].quo[GW - 1 - i] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_valid_reg[i] <= 1'b0;
            end else if (d_en[i]) begin
                d_valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (d_en[i] && src_valid) begin
                d_reg[i] <= d_next[i];
            end
        end
    end

    // stage r: group check, table access, index times record size
    div_t        rs;
    logic        rs_valid;
    logic [29:0] r_prod;
    logic [31:0] slot_wide;

    assign rs        = d_reg[GW-1];
    assign rs_valid  = d_valid_reg[GW-1];
    assign r_prod    = 30'(rs.rem[16:0]) * 30'(inode_bytes_reg);
    assign slot_wide = 32'(rs.slot);

    always_comb begin
        r_next.load   = rs.load;
        r_next.status = rs.status;
        r_next.part   = 40'(part_start_reg) + 40'(r_prod[29:9]);
        r_next.offset = r_prod[8:0];
        if (!rs.load && rs.status == e2il_pkg::STATUS_OK &&
            LW'(rs.quo) >= LW'(giu_reg)) begin
            r_next.status = e2il_pkg::STATUS_NO_GROUP;
        end
    end

    assign ram_we    = r_en && rs_valid && rs.load && (slot_wide < 32'(MAX_GROUPS));
    assign ram_waddr = slot_wide[GW-1:0];
    assign ram_re    = r_en && rs_valid && !rs.load;

    e2il_ram #(
        .WIDTH (32),
        .DEPTH (MAX_GROUPS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rs.tb),
        .re    (ram_re),
        .raddr (rs.quo),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (r_en) begin
            r_valid_reg <= rs_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_en && rs_valid) begin
            r_reg <= r_next;
        end
    end

    // output stage: add the table block scaled to sectors
    logic [3:0] shamt;

    assign shamt = 4'(bsl_reg) + 4'd1;

    always_comb begin
        m_data_next.disk_sector   = '0;
        m_data_next.sector_offset = '0;
        m_data_next.status        = r_reg.status;
        if (!r_reg.load && r_reg.status == e2il_pkg::STATUS_OK) begin
            m_data_next.disk_sector   = r_reg.part + (40'(ram_rdata) << shamt);
            m_data_next.sector_offset = r_reg.offset;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && r_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/core/e2il_checker.sv
// port-level checks of the ext2 inode locator and their binding
module e2il_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input e2il_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input e2il_pkg::out_t m_data
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;

    always_comb begin
        pending_next = pending_reg;
        if (s_valid && s_ready) begin
            pending_next = pending_next + 8'd1;
        end
        if (m_valid && m_ready) begin
            pending_next = pending_next - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != e2il_pkg::STATUS_OK |->
            m_data.disk_sector == 40'd0 && m_data.sector_offset == 9'd0)
        else $error("error result carries an address");

    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output free");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 8'd0)
        else $error("result without an item");

endmodule

bind ext2_inode_locator e2il_checker u_e2il_checker (.*);
